@@ rtl/cbm_pkg.sv @@
package cbm_pkg;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   localparam logic [3:0] CART_NONE   = 4'd0;
   localparam logic [3:0] CART_8K     = 4'd1;
   localparam logic [3:0] CART_16K    = 4'd2;
   localparam logic [3:0] CART_R8K    = 4'd3;
   localparam logic [3:0] CART_034M   = 4'd4;
   localparam logic [3:0] CART_M091   = 4'd5;
   localparam logic [3:0] CART_32K    = 4'd6;
   localparam logic [3:0] CART_HOT    = 4'd7;
   localparam logic [3:0] CART_64K_F  = 4'd8;
   localparam logic [3:0] CART_64K_R0 = 4'd9;
   localparam logic [3:0] CART_64K_R1 = 4'd10;
   localparam logic [3:0] CART_64K_R2 = 4'd11;

   localparam logic CSR_CART_SEL  = 1'b0;
   localparam logic CSR_SLOT_MASK = 1'b1;

   typedef enum logic [1:0] {
      TGT_MAIN  = 2'd0,
      TGT_LEFT  = 2'd1,
      TGT_RIGHT = 2'd2,
      TGT_NONE  = 2'd3
   } target_type;

   typedef enum logic [1:0] {
      KIND_MAIN = 2'd0,
      KIND_WIN  = 2'd1,
      KIND_CTRL = 2'd2
   } kind_type;

   typedef struct packed {
      target_type  src;
      logic [15:0] off;
   } win_type;

   typedef win_type [3:0] winset_type;

   typedef struct packed {
      kind_type    kind;
      logic        wr;
      logic [15:0] address;
      logic [3:0]  upd;
      winset_type  win;
   } cmd_type;

   typedef struct packed {
      target_type  target;
      logic [15:0] mem_addr;
   } rsp_type;

   typedef struct packed {
      logic [3:0] cart_sel;
      logic [1:0] slot_mask;
      logic       rebuild;
   } cfg_type;

   function automatic win_type mk_win(target_type src, logic [15:0] off);
      win_type e;
      e.src = src;
      e.off = (src == TGT_LEFT || src == TGT_RIGHT) ? off : 16'h0000;
      return e;
   endfunction

   function automatic winset_type build_windows(logic [3:0] cart, logic [1:0] slot);
      winset_type w;
      for (int i = 0; i < 4; i++) begin
         w[i] = mk_win(TGT_MAIN, 16'h0000);
      end
      if (slot[1]) begin
         w[0] = mk_win(TGT_RIGHT, 16'h0000);
         w[1] = mk_win(TGT_RIGHT, 16'h1000);
      end else if (cart == CART_HOT) begin
         w[0] = mk_win(TGT_NONE, 16'h0000);
         w[1] = mk_win(TGT_NONE, 16'h0000);
      end
      if (slot[0]) begin
         case (cart)
            CART_16K: begin
               w[0] = mk_win(TGT_LEFT, 16'h0000);
               w[1] = mk_win(TGT_LEFT, 16'h1000);
               w[2] = mk_win(TGT_LEFT, 16'h2000);
               w[3] = mk_win(TGT_LEFT, 16'h3000);
            end
            CART_HOT: begin
               w[0] = mk_win(TGT_LEFT, 16'h0000);
               w[1] = mk_win(TGT_LEFT, 16'h4000);
               w[2] = mk_win(TGT_LEFT, 16'h8000);
               w[3] = mk_win(TGT_LEFT, 16'h9000);
            end
            CART_034M: begin
               w[2] = mk_win(TGT_LEFT, 16'h0000);
               w[3] = mk_win(TGT_LEFT, 16'h3000);
            end
            CART_M091: begin
               w[2] = mk_win(TGT_LEFT, 16'h1000);
               w[3] = mk_win(TGT_LEFT, 16'h0000);
            end
            CART_32K: begin
               w[0] = mk_win(TGT_LEFT, 16'h0000);
               w[1] = mk_win(TGT_LEFT, 16'h1000);
               w[2] = mk_win(TGT_LEFT, 16'h6000);
               w[3] = mk_win(TGT_LEFT, 16'h7000);
            end
            default: begin
               w[2] = mk_win(TGT_LEFT, 16'h0000);
               w[3] = mk_win(TGT_LEFT, 16'h1000);
            end
         endcase
      end
      return w;
   endfunction

endpackage

@@ rtl/cartridge_bank_mapper.sv @@
// channel  | direction | handshake        | payload
// req      | in        | req_push/full    | req_func, req_address, req_data
// rsp      | out       | rsp_pop/empty    | rsp_target, rsp_mem_addr
// csr      | in        | csr_we           | csr_index, csr_wdata
//
// One beat per cycle sustained while the result queue is not full; a taken beat is registered
// in the command queue after front decode, then in the result queue after window lookup.
// Reset maps all four windows to main memory with both registers cleared.
// A full result queue stalls the window unit, which then backs up the command
// queue and raises req_full.
module cartridge_bank_mapper #(
   parameter int CMD_DEPTH = cbm_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = cbm_pkg::RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_target,
   output logic [15:0] rsp_mem_addr
);

   localparam int CMD_W = $bits(cbm_pkg::cmd_type);
   localparam int RSP_W = $bits(cbm_pkg::rsp_type);

   cbm_pkg::cmd_type cmd_in, cmd_out;
   cbm_pkg::cfg_type cfg;
   cbm_pkg::rsp_type rsp_in, rsp_out;
   logic             cmd_empty, cmd_pop, rsp_full, rsp_push;

   cbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_func    (req_func),
      .req_address (req_address),
      .req_data    (req_data),
      .cmd         (cmd_in),
      .cfg         (cfg)
   );

   cbm_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .din   (cmd_in),
      .full  (req_full),
      .pop   (cmd_pop),
      .dout  (cmd_out),
      .empty (cmd_empty)
   );

   cbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd_out),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   cbm_fifo #(.WIDTH(RSP_W), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp_out),
      .empty (rsp_empty)
   );

   assign rsp_target   = rsp_out.target;
   assign rsp_mem_addr = rsp_out.mem_addr;

endmodule

@@ rtl/cbm_fifo.sv @@
module cbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fifo count overflow");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo push lost");

endmodule

@@ rtl/cbm_front.sv @@
module cbm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [3:0]        csr_wdata,
   input  logic              req_func,
   input  logic [15:0]       req_address,
   input  logic [7:0]        req_data,
   output cbm_pkg::cmd_type  cmd,
   output cbm_pkg::cfg_type  cfg
);

   logic [3:0]  cart_sel_ff, cart_sel_in;
   logic [1:0]  slot_mask_ff, slot_mask_in;
   logic        rebuild_ff, rebuild_in;
   logic        ctrl;
   logic [1:0]  n2;
   logic [2:0]  bank;
   logic [11:0] lo;
   logic        d5_page;

   always_comb begin
      cart_sel_in  = cart_sel_ff;
      slot_mask_in = slot_mask_ff;
      rebuild_in   = 1'b0;
      if (csr_we) begin
         rebuild_in = 1'b1;
         case (csr_index)
            cbm_pkg::CSR_CART_SEL:  cart_sel_in  = csr_wdata;
            cbm_pkg::CSR_SLOT_MASK: slot_mask_in = csr_wdata[1:0];
            default: rebuild_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_sel_ff  <= '0;
         slot_mask_ff <= '0;
         rebuild_ff   <= 1'b0;
      end else begin
         cart_sel_ff  <= cart_sel_in;
         slot_mask_ff <= slot_mask_in;
         rebuild_ff   <= rebuild_in;
      end
   end

   assign cfg.cart_sel  = cart_sel_ff;
   assign cfg.slot_mask = slot_mask_ff;
   assign cfg.rebuild   = rebuild_ff;

   assign lo      = req_address[11:0];
   assign d5_page = (req_address[15:8] == 8'hD5);

   // classify the beat and decode any window change it carries
   always_comb begin
      ctrl    = 1'b0;
      cmd.upd = 4'b0000;
      for (int i = 0; i < 4; i++) begin
         cmd.win[i] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
      end
      n2   = 2'(lo[3:0] - 4'd6);
      bank = (cart_sel_ff == cbm_pkg::CART_64K_F) ? req_address[2:0] : ~req_address[2:0];
      case (cart_sel_ff)
         cbm_pkg::CART_32K: begin
            if (d5_page) begin
               ctrl       = 1'b1;
               cmd.upd    = 4'b0011;
               cmd.win[0] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT,
                                            {1'b0, req_data[1:0], 13'h0000});
               cmd.win[1] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT,
                                            {1'b0, req_data[1:0], 1'b1, 12'h000});
            end
         end
         cbm_pkg::CART_034M: begin
            if (d5_page) begin
               ctrl       = 1'b1;
               cmd.upd    = 4'b1100;
               cmd.win[3] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h3000);
               case (req_address[3:0])
                  4'd0, 4'd1: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h0000);
                  4'd2, 4'd6: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h4000);
                  4'd3, 4'd7: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h1000);
                  4'd4, 4'd5: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h2000);
                  default: begin
                     cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
                     cmd.win[3] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
                  end
               endcase
            end
         end
         cbm_pkg::CART_M091: begin
            if (d5_page) begin
               ctrl       = 1'b1;
               cmd.upd    = 4'b1100;
               cmd.win[3] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h0000);
               case ({req_address[3], req_address[0]})
                  2'b00: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h1000);
                  2'b01: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h3000);
                  2'b11: cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, 16'h2000);
                  default: begin
                     cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
                     cmd.win[3] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
                  end
               endcase
            end
         end
         cbm_pkg::CART_HOT: begin
            if (lo >= 12'hFF6 && lo <= 12'hFF9) begin
               if (req_address[15:12] == 4'h8) begin
                  ctrl       = 1'b1;
                  cmd.upd    = 4'b0001;
                  cmd.win[0] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, {2'b00, n2, 12'h000});
               end else if (req_address[15:12] == 4'h9) begin
                  ctrl       = 1'b1;
                  cmd.upd    = 4'b0010;
                  cmd.win[1] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, {2'b01, n2, 12'h000});
               end
            end
         end
         cbm_pkg::CART_64K_F, cbm_pkg::CART_64K_R0,
         cbm_pkg::CART_64K_R1, cbm_pkg::CART_64K_R2: begin
            case (cart_sel_ff)
               cbm_pkg::CART_64K_F:  ctrl = (req_address[15:4] == 12'hD50);
               cbm_pkg::CART_64K_R0: ctrl = (req_address[15:4] == 12'hD5D);
               cbm_pkg::CART_64K_R1: ctrl = (req_address[15:4] == 12'hD57);
               default:              ctrl = (req_address[15:4] == 12'hD5E);
            endcase
            cmd.upd = 4'b1100;
            if (req_address[3]) begin
               cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
               cmd.win[3] = cbm_pkg::mk_win(cbm_pkg::TGT_MAIN, 16'h0000);
            end else begin
               cmd.win[2] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, {bank, 13'h0000});
               cmd.win[3] = cbm_pkg::mk_win(cbm_pkg::TGT_LEFT, {bank, 1'b1, 12'h000});
            end
         end
         default: ctrl = 1'b0;
      endcase

      cmd.wr      = req_func;
      cmd.address = req_address;
      if (req_func && ctrl) begin
         cmd.kind = cbm_pkg::KIND_CTRL;
      end else begin
         cmd.upd = 4'b0000;
         if (req_address[15:14] == 2'b10) begin
            cmd.kind = cbm_pkg::KIND_WIN;
         end else begin
            cmd.kind = cbm_pkg::KIND_MAIN;
         end
      end
   end

endmodule

@@ rtl/cbm_back.sv @@
module cbm_back (
   input  logic              clock,
   input  logic              reset,
   input  cbm_pkg::cfg_type  cfg,
   input  cbm_pkg::cmd_type  cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output cbm_pkg::rsp_type  rsp
);

   cbm_pkg::winset_type win_ff, win_in;
   cbm_pkg::win_type    cur;
   logic                exec;

   assign exec     = !cmd_empty && !rsp_full;
   assign cmd_pop  = exec;
   assign rsp_push = exec;
   assign cur      = win_ff[cmd.address[13:12]];

   always_comb begin
      rsp.target   = cbm_pkg::TGT_MAIN;
      rsp.mem_addr = cmd.address;
      case (cmd.kind)
         cbm_pkg::KIND_CTRL: begin
            rsp.target   = cbm_pkg::TGT_NONE;
            rsp.mem_addr = 16'h0000;
         end
         cbm_pkg::KIND_WIN: begin
            if (cur.src == cbm_pkg::TGT_NONE || (cmd.wr && cur.src != cbm_pkg::TGT_MAIN)) begin
               rsp.target   = cbm_pkg::TGT_NONE;
               rsp.mem_addr = 16'h0000;
            end else if (cur.src == cbm_pkg::TGT_MAIN) begin
               rsp.target   = cbm_pkg::TGT_MAIN;
               rsp.mem_addr = cmd.address;
            end else begin
               rsp.target   = cur.src;
               rsp.mem_addr = cur.off + {4'h0, cmd.address[11:0]};
            end
         end
         default: begin
            rsp.target   = cbm_pkg::TGT_MAIN;
            rsp.mem_addr = cmd.address;
         end
      endcase
   end

   always_comb begin
      win_in = win_ff;
      if (cfg.rebuild) begin
         win_in = cbm_pkg::build_windows(cfg.cart_sel, cfg.slot_mask);
      end else if (exec && cmd.kind == cbm_pkg::KIND_CTRL) begin
         for (int i = 0; i < 4; i++) begin
            if (cmd.upd[i]) begin
               win_in[i] = cmd.win[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= cbm_pkg::build_windows(cbm_pkg::CART_NONE, 2'b00);
      end else begin
         win_ff <= win_in;
      end
   end

   a_rebuild_right: assert property (@(posedge clock) disable iff (reset)
      (cfg.rebuild && cfg.slot_mask == 2'b10) |=> (win_ff[0].src == cbm_pkg::TGT_RIGHT))
      else $error("right slot not mapped after rebuild");

   a_ctrl_none: assert property (@(posedge clock) disable iff (reset)
      (exec && cmd.kind == cbm_pkg::KIND_CTRL) |-> (rsp.target == cbm_pkg::TGT_NONE))
      else $error("control beat reached memory");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cbm_pkg::*;

   localparam logic       ACC_READ       = 1'b0;
   localparam logic       ACC_WRITE      = 1'b1;
   localparam logic [3:0] CART_UNUSED_HI = 4'd15;
   localparam int         NUM_PHASES     = 32;
   localparam int         CHUNK_ITEMS    = 15;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         CYCLE_LIMIT    = 200000;

   typedef struct packed {
      logic        func;
      logic [15:0] address;
      logic [7:0]  data;
   } access_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_wdata = 4'h0;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_func = 1'b0;
   logic [15:0] req_address = 16'h0000;
   logic [7:0]  req_data = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_target;
   logic [15:0] rsp_mem_addr;

   access_type access_queue[$];
   rsp_type    xlat_queue[$];
   logic       offering = 1'b0;
   int         tx_idle_pct = 0;
   int         rx_stall_pct = 0;
   logic       hold_kick = 1'b0;
   int         rx_hold_left = 0;
   int         cycle_count = 0;
   int         mismatches = 0;

   logic [3:0] cart_cfg;
   logic [1:0] slot_cfg;
   target_type win_src[4];
   logic [15:0] win_off[4];

   cartridge_bank_mapper u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_address  (req_address),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_target   (rsp_target),
      .rsp_mem_addr (rsp_mem_addr)
   );

   always #5 clock = ~clock;

   task automatic set_window(input int w, input target_type src, input logic [15:0] off);
      win_src[w] = src;
      win_off[w] = off;
   endtask

   task automatic reload_windows();
      for (int i = 0; i < 4; i++) begin
         set_window(i, TGT_MAIN, 16'h0000);
      end
      if (slot_cfg[1]) begin
         set_window(0, TGT_RIGHT, 16'h0000);
         set_window(1, TGT_RIGHT, 16'h1000);
      end else if (cart_cfg == CART_HOT) begin
         set_window(0, TGT_NONE, 16'h0000);
         set_window(1, TGT_NONE, 16'h0000);
      end
      if (slot_cfg[0]) begin
         case (cart_cfg)
            CART_16K: begin
               for (int i = 0; i < 4; i++) begin
                  set_window(i, TGT_LEFT, {2'b00, i[1:0], 12'h000});
               end
            end
            CART_HOT: begin
               set_window(0, TGT_LEFT, 16'h0000);
               set_window(1, TGT_LEFT, 16'h4000);
               set_window(2, TGT_LEFT, 16'h8000);
               set_window(3, TGT_LEFT, 16'h9000);
            end
            CART_034M: begin
               set_window(2, TGT_LEFT, 16'h0000);
               set_window(3, TGT_LEFT, 16'h3000);
            end
            CART_M091: begin
               set_window(2, TGT_LEFT, 16'h1000);
               set_window(3, TGT_LEFT, 16'h0000);
            end
            CART_32K: begin
               set_window(0, TGT_LEFT, 16'h0000);
               set_window(1, TGT_LEFT, 16'h1000);
               set_window(2, TGT_LEFT, 16'h6000);
               set_window(3, TGT_LEFT, 16'h7000);
            end
            default: begin
               set_window(2, TGT_LEFT, 16'h0000);
               set_window(3, TGT_LEFT, 16'h1000);
            end
         endcase
      end
   endtask

   // Apply one bus access to the window state and work out its translation.
   task automatic translate_access(input logic wr, input logic [15:0] addr,
         input logic [7:0] data, output rsp_type xlat);
      logic        hit;
      logic        d5_page;
      logic [2:0]  bank;
      logic [11:0] match;
      logic [15:0] lo;
      logic [15:0] hot_n;
      int          w;
      hit = 1'b0;
      d5_page = (addr[15:8] == 8'hd5);
      lo = {4'h0, addr[11:0]};
      hot_n = lo - 16'h0ff6;
      if (wr) begin
         case (cart_cfg)
            CART_32K: begin
               if (d5_page) begin
                  hit = 1'b1;
                  set_window(0, TGT_LEFT, {1'b0, data[1:0], 13'h0000});
                  set_window(1, TGT_LEFT, {1'b0, data[1:0], 1'b1, 12'h000});
               end
            end
            CART_034M: begin
               if (d5_page) begin
                  hit = 1'b1;
                  if (addr[3]) begin
                     set_window(2, TGT_MAIN, 16'h0000);
                     set_window(3, TGT_MAIN, 16'h0000);
                  end else begin
                     case (addr[2:0])
                        3'd0, 3'd1: set_window(2, TGT_LEFT, 16'h0000);
                        3'd2, 3'd6: set_window(2, TGT_LEFT, 16'h4000);
                        3'd3, 3'd7: set_window(2, TGT_LEFT, 16'h1000);
                        default:    set_window(2, TGT_LEFT, 16'h2000);
                     endcase
                     set_window(3, TGT_LEFT, 16'h3000);
                  end
               end
            end
            CART_M091: begin
               if (d5_page) begin
                  hit = 1'b1;
                  case ({addr[3], addr[0]})
                     2'b00: set_window(2, TGT_LEFT, 16'h1000);
                     2'b01: set_window(2, TGT_LEFT, 16'h3000);
                     2'b11: set_window(2, TGT_LEFT, 16'h2000);
                     default: set_window(2, TGT_MAIN, 16'h0000);
                  endcase
                  if (win_src[2] == TGT_MAIN) begin
                     set_window(3, TGT_MAIN, 16'h0000);
                  end else begin
                     set_window(3, TGT_LEFT, 16'h0000);
                  end
               end
            end
            CART_HOT: begin
               if (lo >= 16'h0ff6 && lo <= 16'h0ff9) begin
                  if (addr[15:12] == 4'h8) begin
                     hit = 1'b1;
                     set_window(0, TGT_LEFT, {hot_n[3:0], 12'h000});
                  end else if (addr[15:12] == 4'h9) begin
                     hit = 1'b1;
                     set_window(1, TGT_LEFT, 16'h4000 + {hot_n[3:0], 12'h000});
                  end
               end
            end
            CART_64K_F, CART_64K_R0, CART_64K_R1, CART_64K_R2: begin
               case (cart_cfg)
                  CART_64K_F:  match = 12'hd50;
                  CART_64K_R0: match = 12'hd5d;
                  CART_64K_R1: match = 12'hd57;
                  default:     match = 12'hd5e;
               endcase
               if (addr[15:4] == match) begin
                  hit = 1'b1;
                  if (addr[3]) begin
                     set_window(2, TGT_MAIN, 16'h0000);
                     set_window(3, TGT_MAIN, 16'h0000);
                  end else begin
                     bank = (cart_cfg == CART_64K_F) ? addr[2:0] : ~addr[2:0];
                     set_window(2, TGT_LEFT, {bank, 13'h0000});
                     set_window(3, TGT_LEFT, {bank, 1'b1, 12'h000});
                  end
               end
            end
            default: hit = 1'b0;
         endcase
      end
      if (hit) begin
         xlat.target = TGT_NONE;
         xlat.mem_addr = 16'h0000;
      end else if (addr[15:14] == 2'b10) begin
         w = addr[13:12];
         xlat.target = win_src[w];
         if (win_src[w] == TGT_NONE || (wr && win_src[w] != TGT_MAIN)) begin
            xlat.target = TGT_NONE;
            xlat.mem_addr = 16'h0000;
         end else if (win_src[w] == TGT_MAIN) begin
            xlat.mem_addr = addr;
         end else begin
            xlat.mem_addr = win_off[w] + lo;
         end
      end else begin
         xlat.target = TGT_MAIN;
         xlat.mem_addr = addr;
      end
   endtask

   task automatic add_access(input logic func, input logic [15:0] addr, input logic [7:0] data);
      access_type a;
      a.func = func;
      a.address = addr;
      a.data = data;
      access_queue.push_back(a);
   endtask

   // Mostly bank switches followed by window traffic, the rest random noise.
   task automatic queue_traffic(input int count);
      int          added;
      int          pick;
      logic [15:0] addr;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(99);
         addr = $urandom;
         if (pick < 45) begin
            case ($urandom_range(6))
               0: addr[15:8] = 8'hd5;
               1: addr[15:4] = 12'hd50;
               2: addr[15:4] = 12'hd5d;
               3: addr[15:4] = 12'hd57;
               4: addr[15:4] = 12'hd5e;
               5: addr = {3'b100, addr[0], 12'hff6 + 12'($urandom_range(3))};
               default: addr = {3'b100, addr[0], addr[1] ? 12'hffa : 12'hff5};
            endcase
            add_access(ACC_WRITE, addr, 8'($urandom));
            added++;
            repeat ($urandom_range(4, 1)) begin
               addr = $urandom;
               add_access($urandom_range(3) == 0, {2'b10, addr[13:0]}, 8'($urandom));
               added++;
            end
         end else if (pick < 75) begin
            add_access(1'($urandom), {2'b10, addr[13:0]}, 8'($urandom));
            added++;
         end else begin
            add_access(1'($urandom), addr, 8'($urandom));
            added++;
         end
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (access_queue.size() != 0 || offering || xlat_queue.size() != 0);
   endtask

   task automatic write_reg(input logic idx, input logic [3:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_CART_SEL) begin
         cart_cfg = value;
      end else begin
         slot_cfg = value[1:0];
      end
      reload_windows();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int p);
      logic [3:0] slot_word;
      slot_word = {2'($urandom), p[0] ^ p[4], ~p[4]};
      wait_idle();
      if ($urandom_range(1)) begin
         write_reg(CSR_CART_SEL, p[3:0]);
         write_reg(CSR_SLOT_MASK, slot_word);
      end else begin
         write_reg(CSR_SLOT_MASK, slot_word);
         write_reg(CSR_CART_SEL, p[3:0]);
      end
      case (p % 4)
         0: begin
            tx_idle_pct <= 0;
            rx_stall_pct <= 0;
         end
         1: begin
            tx_idle_pct <= 63;
            rx_stall_pct <= 0;
         end
         2: begin
            tx_idle_pct <= 0;
            rx_stall_pct <= 63;
         end
         default: begin
            tx_idle_pct <= 23;
            rx_stall_pct <= 23;
         end
      endcase
      queue_traffic(CHUNK_ITEMS);
      if (p == 4 || p == 22) begin
         hold_kick <= 1'b1;
         @(posedge clock);
         hold_kick <= 1'b0;
      end
      // drain fully before the second half
      wait_idle();
      queue_traffic(CHUNK_ITEMS);
   endtask

   initial begin
      cart_cfg = CART_NONE;
      slot_cfg = 2'b00;
      reload_windows();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_CART_SEL, CART_HOT);
      write_reg(CSR_SLOT_MASK, 4'h0);
      add_access(ACC_READ,  16'h8000, 8'h00);
      add_access(ACC_READ,  16'h9fff, 8'hff);
      add_access(ACC_WRITE, 16'h8ff6, 8'h00);
      add_access(ACC_READ,  16'h8fff, 8'h00);
      add_access(ACC_WRITE, 16'h9ff9, 8'hff);
      add_access(ACC_READ,  16'h9000, 8'h00);
      add_access(ACC_WRITE, 16'h8ff5, 8'hff);
      add_access(ACC_READ,  16'h0000, 8'h00);
      add_access(ACC_READ,  16'hffff, 8'h00);
      add_access(ACC_WRITE, 16'hc000, 8'hff);
      wait_idle();

      write_reg(CSR_CART_SEL, CART_64K_F);
      write_reg(CSR_SLOT_MASK, 4'h3);
      add_access(ACC_READ,  16'h8000, 8'h00);
      add_access(ACC_WRITE, 16'hd500, 8'h00);
      add_access(ACC_READ,  16'ha000, 8'h00);
      add_access(ACC_WRITE, 16'hd507, 8'hff);
      add_access(ACC_READ,  16'hbfff, 8'h00);
      add_access(ACC_WRITE, 16'hd508, 8'h00);
      add_access(ACC_READ,  16'ha123, 8'h00);
      add_access(ACC_WRITE, 16'ha123, 8'h5a);
      add_access(ACC_WRITE, 16'h9000, 8'ha5);
      add_access(ACC_READ,  16'h7fff, 8'h00);
      wait_idle();

      write_reg(CSR_CART_SEL, CART_UNUSED_HI);
      write_reg(CSR_SLOT_MASK, 4'hd);
      add_access(ACC_READ, 16'ha000, 8'h00);
      add_access(ACC_READ, 16'hb000, 8'h00);
      add_access(ACC_WRITE, 16'hbfff, 8'hff);

      for (int p = 0; p < NUM_PHASES; p++) begin
         run_phase(p);
      end
      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   always @(posedge clock) begin : drive_req
      rsp_type xlat;
      access_type a;
      if (reset) begin
         req_push <= 1'b0;
         offering = 1'b0;
      end else begin
         if (offering && !req_full) begin
            translate_access(req_func, req_address, req_data, xlat);
            xlat_queue.push_back(xlat);
            offering = 1'b0;
         end
         if (!offering && access_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            a = access_queue.pop_front();
            req_func <= a.func;
            req_address <= a.address;
            req_data <= a.data;
            offering = 1'b1;
         end
         req_push <= offering;
      end
   end

   always @(posedge clock) begin : rx_hold
      if (hold_kick) begin
         rx_hold_left <= HOLD_CYCLES;
      end else if (rx_hold_left != 0) begin
         rx_hold_left <= rx_hold_left - 1;
      end
   end

   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (xlat_queue.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat, expected none, actual target=%0d mem_addr=%h",
                        $time, rsp_target, rsp_mem_addr);
            end else begin
               want = xlat_queue.pop_front();
               if (rsp_target !== want.target) begin
                  mismatches++;
                  $display("%0t: target mismatch, expected %0d, actual %0d",
                           $time, want.target, rsp_target);
               end
               if (rsp_mem_addr !== want.mem_addr) begin
                  mismatches++;
                  $display("%0t: mem_addr mismatch, expected %h, actual %h",
                           $time, want.mem_addr, rsp_mem_addr);
               end
            end
         end
         rsp_pop <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
